// ----- sv/assert_macros.svh -----
// Assertion macros shared by the door remote status sequencer RTL.
// Each macro turns into a labeled concurrent assertion in simulation and into
// nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside of reset.
`define DRSS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("door remote status sequencer assertion failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define DRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("door remote status sequencer assertion failed");

`else

`define DRSS_ASSERT(label, clk, rst_n, prop)
`define DRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/drss_pkg.sv -----
// Types, codes and helper functions of the door remote status sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package drss_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned CHG_W    = 8;
  localparam int unsigned CFG_W    = (TIMER_W > SAMPLE_W) ? TIMER_W : SAMPLE_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [CHG_W-1:0]   CHG_MAX   = {CHG_W{1'b1}};

  // Request codes carried by each tick.
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_OPEN   = 2'd1;
  localparam logic [1:0] REQ_CLOSE  = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_END  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTV = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDBY    = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT     = 3'd1,
    PH_BLINK    = 3'd2,
    PH_EVAL     = 3'd3,
    PH_LOCKED   = 3'd4,
    PH_UNLOCKED = 3'd5,
    PH_LINKFAIL = 3'd6,
    PH_READERR  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_STANDBY  = 3'd0,
    ST_CHECKING = 3'd1,
    ST_LOCKED   = 3'd2,
    ST_UNLOCKED = 3'd3,
    ST_LINKFAIL = 3'd4,
    ST_READERR  = 3'd5
  } status_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_thr;
    logic [SAMPLE_W-1:0] low_thr;
    logic [TIMER_W-1:0]  press_ms;
    logic [TIMER_W-1:0]  sample_ms;
    logic [TIMER_W-1:0]  blink_start_ms;
    logic [TIMER_W-1:0]  blink_end_ms;
    logic [TIMER_W-1:0]  blink_intv_ms;
    logic [TIMER_W-1:0]  standby_ms;
  } cfg_t;

  typedef struct packed {
    phase_e              phase;
    logic [1:0]          kind;
    logic [TIMER_W-1:0]  elapsed;
    logic                green_seen;
    logic                red_seen;
    logic                link_err;
    logic                blink_started;
    logic [TIMER_W-1:0]  blink_wait;
    logic                light_now;
    logic                light_prev;
    logic [CHG_W-1:0]    changes;
    status_e             prev_result;
  } seq_t;

  typedef struct packed {
    logic    open_pressed;
    logic    close_pressed;
    status_e status;
    status_e last_status;
  } res_t;

  // Status shown for a phase.
  function automatic status_e phase_status(phase_e ph);
    status_e s;
    case (ph)
      PH_IDLE:     s = ST_STANDBY;
      PH_WAIT:     s = ST_CHECKING;
      PH_BLINK:    s = ST_CHECKING;
      PH_EVAL:     s = ST_CHECKING;
      PH_LOCKED:   s = ST_LOCKED;
      PH_UNLOCKED: s = ST_UNLOCKED;
      PH_LINKFAIL: s = ST_LINKFAIL;
      PH_READERR:  s = ST_READERR;
      default:     s = ST_STANDBY;
    endcase
    return s;
  endfunction

  // Sequence state with everything but the last result cleared.
  function automatic seq_t seq_cleared(status_e prev);
    seq_t c;
    c             = '0;
    c.phase       = PH_IDLE;
    c.prev_result = prev;
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/drss_cfg.sv -----
// Configuration register file of the door remote status sequencer.
// Depends on drss_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module drss_cfg
  import drss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_THR:   cfg_d.high_thr       = cfg_data_i[SAMPLE_W-1:0];
        CFG_LOW_THR:    cfg_d.low_thr        = cfg_data_i[SAMPLE_W-1:0];
        CFG_PRESS:      cfg_d.press_ms       = cfg_data_i[TIMER_W-1:0];
        CFG_SAMPLE:     cfg_d.sample_ms      = cfg_data_i[TIMER_W-1:0];
        CFG_BLINK_ST:   cfg_d.blink_start_ms = cfg_data_i[TIMER_W-1:0];
        CFG_BLINK_END:  cfg_d.blink_end_ms   = cfg_data_i[TIMER_W-1:0];
        CFG_BLINK_INTV: cfg_d.blink_intv_ms  = cfg_data_i[TIMER_W-1:0];
        CFG_STANDBY:    cfg_d.standby_ms     = cfg_data_i[TIMER_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr       <= SAMPLE_W'(614);
      cfg_q.low_thr        <= SAMPLE_W'(164);
      cfg_q.press_ms       <= TIMER_W'(500);
      cfg_q.sample_ms      <= TIMER_W'(2200);
      cfg_q.blink_start_ms <= TIMER_W'(3500);
      cfg_q.blink_end_ms   <= TIMER_W'(8000);
      cfg_q.blink_intv_ms  <= TIMER_W'(220);
      cfg_q.standby_ms     <= TIMER_W'(10000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/drss_step.sv -----
// One-tick update of the sequence state and the result it produces.
// Purely combinational; depends on drss_pkg for state, config and result types.
`default_nettype none

module drss_step
  import drss_pkg::*;
(
  input  wire seq_t                 cur_i,
  input  wire logic [1:0]           req_i,
  input  wire logic [SAMPLE_W-1:0]  smp_i,
  input  wire cfg_t                 cfg_i,
  output seq_t                      nxt_o,
  output res_t                      res_o
);

  // Next state.
  always_comb begin
    seq_t n;
    logic hi;
    logic lo;
    n  = cur_i;
    hi = (smp_i >= cfg_i.high_thr);
    lo = (smp_i < cfg_i.low_thr);

    if (cur_i.phase == PH_IDLE) begin
      if (req_i != REQ_NONE) begin
        n       = seq_cleared(cur_i.prev_result);
        n.kind  = req_i;
        n.phase = PH_WAIT;
      end
    end else if (cur_i.elapsed != TIMER_MAX) begin
      n.elapsed = cur_i.elapsed + TIMER_W'(1);
    end

    // Single color read once the sample time has passed.
    if (n.phase == PH_WAIT && n.elapsed > cfg_i.sample_ms) begin
      if (hi) begin
        n.green_seen = 1'b1;
      end else begin
        n.red_seen = 1'b1;
      end
      n.phase = PH_BLINK;
    end

    if (n.phase == PH_BLINK) begin
      if (n.elapsed > cfg_i.blink_start_ms) begin
        if (!n.blink_started) begin
          n.blink_started = 1'b1;
          n.blink_wait    = '0;
          if (hi) begin
            n.light_now  = 1'b1;
            n.light_prev = 1'b1;
          end
          if (lo) begin
            n.light_now  = 1'b0;
            n.light_prev = 1'b0;
          end
        end else if (n.blink_wait != TIMER_MAX) begin
          n.blink_wait = n.blink_wait + TIMER_W'(1);
        end
        if (n.blink_wait > cfg_i.blink_intv_ms) begin
          if (hi) begin
            n.light_now = 1'b1;
          end
          if (lo) begin
            n.light_now = 1'b0;
          end
          if (n.light_now != n.light_prev) begin
            if (n.changes != CHG_MAX) begin
              n.changes = n.changes + CHG_W'(1);
            end
            n.light_prev = n.light_now;
          end
          n.blink_wait = '0;
        end
      end
      if (n.elapsed > cfg_i.blink_end_ms) begin
        if (n.changes > CHG_W'(2)) begin
          n.link_err   = 1'b1;
          n.green_seen = 1'b0;
          n.red_seen   = 1'b0;
        end
        n.phase = PH_EVAL;
      end
    end

    // Pick the result by request kind.
    if (n.phase == PH_EVAL) begin
      n.phase = PH_READERR;
      if (n.link_err) begin
        n.phase = PH_LINKFAIL;
      end else begin
        case (n.kind)
          REQ_STATUS: begin
            if (n.green_seen) begin
              n.phase = PH_LOCKED;
            end else if (n.red_seen) begin
              n.phase = PH_UNLOCKED;
            end
          end
          REQ_CLOSE: begin
            if (n.green_seen) begin
              n.phase = PH_LOCKED;
            end
          end
          REQ_OPEN: begin
            if (n.red_seen) begin
              n.phase = PH_UNLOCKED;
            end
          end
          default: n.phase = PH_READERR;
        endcase
      end
    end

    if (n.phase != PH_IDLE && n.elapsed > cfg_i.standby_ms) begin
      n = seq_cleared(phase_status(n.phase));
    end

    nxt_o = n;
  end

  // Result of the tick, taken from the updated state.
  always_comb begin
    logic press;
    press = (nxt_o.phase != PH_IDLE) && (nxt_o.elapsed < cfg_i.press_ms);
    res_o.open_pressed  = press & nxt_o.kind[0];
    res_o.close_pressed = press & nxt_o.kind[1];
    res_o.status        = phase_status(nxt_o.phase);
    res_o.last_status   = nxt_o.prev_result;
  end

endmodule

`default_nettype wire

// ----- sv/door_remote_status_sequencer.sv -----
// Top level of the door remote status sequencer: input register, tick update,
// result register. Depends on drss_pkg, drss_cfg, drss_step and assert_macros.svh.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------------------
//   in       | in_valid_i / in_stall_o      | request_i, led_sample_i
//   out      | out_valid_o / out_stall_i    | open/close_relay_pressed_o, status_o,
//            |                              | last_status_o
//   cfg      | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// Each beat is one millisecond tick and lands in the input register; once the
// result register is free or being emptied, the tick update runs and loads its
// result into the result register. While in_stall_o is low, a new beat can be
// taken every cycle. The result register is the only place a downstream stall holds
// work; the input register stalls only while the result register is full and stalled.
// Reset clears the sequence state to standby and loads the default configuration.
`default_nettype none
`include "assert_macros.svh"

module door_remote_status_sequencer
  import drss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // Tick input channel.
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [1:0]           request_i,
  input  wire logic [SAMPLE_W-1:0]  led_sample_i,
  // Result channel.
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic                 open_relay_pressed_o,
  output      logic                 close_relay_pressed_o,
  output      logic [2:0]           status_o,
  output      logic [2:0]           last_status_o
);

  cfg_t cfg;

  drss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register.
  logic                in_vld_q, in_vld_d;
  logic [1:0]          in_req_q;
  logic [SAMPLE_W-1:0] in_smp_q;

  // Result register.
  logic out_vld_q, out_vld_d;
  res_t out_q;

  // Sequence state.
  seq_t st_q, st_d;
  res_t res;

  logic advance;
  logic in_take;

  // The buffered tick moves on when the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  drss_step u_step (
    .cur_i (st_q),
    .req_i (in_req_q),
    .smp_i (in_smp_q),
    .cfg_i (cfg),
    .nxt_o (st_d),
    .res_o (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= seq_cleared(ST_STANDBY);
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= request_i;
      in_smp_q <= led_sample_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign open_relay_pressed_o  = out_q.open_pressed;
  assign close_relay_pressed_o = out_q.close_pressed;
  assign status_o              = out_q.status;
  assign last_status_o         = out_q.last_status;

  // A pressed relay is only ever reported while a sequence is running.
  `DRSS_ASSERT(a_press_busy, clk_i, rst_ni,
               !(out_vld_q && (out_q.open_pressed || out_q.close_pressed)
                 && out_q.status == ST_STANDBY))
  // Standby always comes with a cleared sequence timer.
  `DRSS_ASSERT(a_idle_clear, clk_i, rst_ni, st_q.phase != PH_IDLE || st_q.elapsed == '0)
  // Every tick that moves on yields a result in the next cycle.
  `DRSS_ASSERT_NEXT(a_adv_out, clk_i, rst_ni, advance, out_vld_q)

endmodule

`default_nettype wire
